// File: rtl/tlvp_pkg.sv
package tlvp_pkg;

	// record kinds, carried on m_tuser
	localparam logic KIND_FIELD  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// type byte decoding
	localparam logic [7:0]  WIDTH_MASK    = 8'h0F;
	localparam logic [7:0]  TEXT_TYPE_MIN = 8'h10;
	// bit n set: a width nibble of n is not allowed (only 1, 2, 4, 8 are)
	localparam logic [15:0] BAD_WIDTH     = 16'b1111_1110_1110_1001;

	// header: main id and assist id, two bytes each
	localparam int HDR_BYTES = 4;

	// result queue depth, room for two records from one item
	localparam int QUEUE_DEPTH = 4;

	// packed result data width: 170 bits of fields, padded to bytes
	localparam int OUT_TDATA_W = 176;

	typedef struct packed {
		logic        kind;
		logic [7:0]  key;
		logic        is_text;
		logic [31:0] offset;
		logic [31:0] length;
		logic [63:0] number;
		logic [15:0] main_id;
		logic [15:0] assist_id;
		logic        valid;
		logic        eor;
	} rec_t;

	// records pushed by one accepted item
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

// File: rtl/tlvp_core.sv
module tlvp_core #(
	parameter int OFFSET_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output tlvp_pkg::rec_t   rec0,
	output tlvp_pkg::rec_t   rec1,
	output tlvp_pkg::push_t  push
);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_TYPE   = 3'd3;
	localparam logic [2:0] PH_KEY    = 3'd4;
	localparam logic [2:0] PH_NUMBER = 3'd5;
	localparam logic [2:0] PH_PREFIX = 3'd6;
	localparam logic [2:0] PH_TEXT   = 3'd7;

	localparam int CW = (OFFSET_BITS + 1 > 32) ? OFFSET_BITS + 1 : 32;
	localparam logic [63:0] OFF_MAX = (OFFSET_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << OFFSET_BITS) - 64'd1);

	logic [15:0]            skip_cfg_q;
	logic [2:0]             phase_q, phase_n;
	logic [15:0]            skip_left_q, skip_left_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [3:0]             sub_q, sub_n;
	logic [3:0]             width_q, width_n;
	logic                   text_q, text_n;
	logic [7:0]             key_q, key_n;
	logic [63:0]            acc_q, acc_n;
	logic [OFFSET_BITS-1:0] left_q, left_n;
	logic [15:0]            main_q, main_n;
	logic [15:0]            assist_q, assist_n;
	logic                   err_q, err_n;
	logic                   done_q, done_n;

	logic                   made;
	tlvp_pkg::rec_t         fld_rec;
	tlvp_pkg::rec_t         sts_rec;

	// OR a byte into one byte lane of the accumulator
	function automatic logic [63:0] lane_or(input logic [63:0] acc, input logic [7:0] b,
			input logic [2:0] lane);
		logic [63:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (lane == 3'(i)) begin
				r[8*i +: 8] = acc[8*i +: 8] | b;
			end
		end
		return r;
	endfunction

	// next state and field record for the byte on the input
	always_comb begin
		logic            consumed;
		logic [CW-1:0]   pos_ext;
		logic [OFFSET_BITS-1:0] left_dec;
		phase_n   = phase_q;
		skip_left_n = skip_left_q;
		pos_n     = pos_q;
		sub_n     = sub_q;
		width_n   = width_q;
		text_n    = text_q;
		key_n     = key_q;
		acc_n     = acc_q;
		left_n    = left_q;
		main_n    = main_q;
		assist_n  = assist_q;
		err_n     = err_q;
		done_n    = done_q;
		made      = 1'b0;
		consumed  = 1'b0;
		pos_ext   = CW'(pos_q);
		left_dec  = left_q - OFFSET_BITS'(left_q != '0);
		fld_rec   = '0;
		fld_rec.kind = tlvp_pkg::KIND_FIELD;
		fld_rec.key  = key_q;
		fld_rec.eor  = !last_byte;

		if (!err_q) begin
			// discard the leading bytes
			if (phase_q == PH_START) begin
				skip_left_n = skip_cfg_q;
				if (skip_cfg_q != '0) begin
					skip_left_n = skip_cfg_q - 16'd1;
					consumed    = 1'b1;
					phase_n     = (skip_cfg_q != 16'd1) ? PH_SKIP : PH_HEADER;
				end else begin
					phase_n = PH_HEADER;
				end
				sub_n = '0;
				acc_n = '0;
			end else if (phase_q == PH_SKIP) begin
				if (skip_left_q != '0) begin
					skip_left_n = skip_left_q - 16'd1;
				end
				consumed = 1'b1;
				if (skip_left_n == '0) begin
					phase_n = PH_HEADER;
				end
			end

			if (!consumed) begin
				// saturate the byte position
				if (pos_q != '1) begin
					pos_n = pos_q + OFFSET_BITS'(1);
				end
				case (phase_n)
					PH_HEADER: begin
						acc_n = lane_or(acc_n, data_byte, {1'b0, sub_n[1:0]});
						sub_n = sub_n + 4'd1;
						if (sub_n >= 4'(tlvp_pkg::HDR_BYTES)) begin
							main_n   = acc_n[15:0];
							assist_n = acc_n[31:16];
							acc_n    = '0;
							sub_n    = '0;
							done_n   = 1'b0;
							phase_n  = PH_TYPE;
						end
					end
					PH_TYPE: begin
						done_n = 1'b0;
						if (tlvp_pkg::BAD_WIDTH[data_byte[3:0]]) begin
							err_n = 1'b1;
						end else begin
							width_n = 4'(data_byte & tlvp_pkg::WIDTH_MASK);
							text_n  = data_byte > tlvp_pkg::TEXT_TYPE_MIN;
							phase_n = PH_KEY;
						end
					end
					PH_KEY: begin
						key_n   = data_byte;
						acc_n   = '0;
						sub_n   = '0;
						phase_n = text_q ? PH_PREFIX : PH_NUMBER;
					end
					PH_NUMBER: begin
						acc_n = lane_or(acc_q, data_byte, sub_q[2:0]);
						sub_n = sub_q + 4'd1;
						if (sub_n >= width_q) begin
							made           = 1'b1;
							fld_rec.offset = 32'(pos_ext + CW'(1) - CW'(width_q));
							fld_rec.length = 32'(width_q);
							fld_rec.number = acc_n;
							done_n         = 1'b1;
							phase_n        = PH_TYPE;
						end
					end
					PH_PREFIX: begin
						acc_n = lane_or(acc_q, data_byte, sub_q[2:0]);
						sub_n = sub_q + 4'd1;
						if (sub_n >= width_q) begin
							// zero or over-range length ends the packet parse
							if (acc_n == '0 || acc_n > OFF_MAX) begin
								err_n  = 1'b1;
								done_n = 1'b0;
							end else begin
								left_n  = acc_n[OFFSET_BITS-1:0];
								phase_n = PH_TEXT;
							end
						end
					end
					PH_TEXT: begin
						left_n = left_dec;
						if (left_dec == '0) begin
							made            = 1'b1;
							fld_rec.is_text = 1'b1;
							fld_rec.offset  = 32'(pos_ext + CW'(1) -
								CW'(acc_q[OFFSET_BITS-1:0]));
							fld_rec.length  = acc_q[31:0];
							done_n          = 1'b1;
							phase_n         = PH_TYPE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// status record from the state left by this byte
	always_comb begin
		sts_rec           = '0;
		sts_rec.kind      = tlvp_pkg::KIND_STATUS;
		sts_rec.main_id   = main_n;
		sts_rec.assist_id = assist_n;
		sts_rec.valid     = done_n && !err_n;
		sts_rec.eor       = 1'b1;
	end

	assign rec0        = made ? fld_rec : sts_rec;
	assign rec1        = sts_rec;
	assign push.first  = accept && (made || last_byte);
	assign push.second = accept && made && last_byte;

	// hold the skip register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_cfg_q <= '0;
		end else if (cfg_wr_en) begin
			skip_cfg_q <= cfg_wr_data;
		end
	end

	// advance parse state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			skip_left_q <= '0;
			pos_q       <= '0;
			sub_q       <= '0;
			width_q     <= '0;
			text_q      <= 1'b0;
			key_q       <= '0;
			acc_q       <= '0;
			left_q      <= '0;
			main_q      <= '0;
			assist_q    <= '0;
			err_q       <= 1'b0;
			done_q      <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q     <= PH_START;
				skip_left_q <= '0;
				pos_q       <= '0;
				sub_q       <= '0;
				width_q     <= '0;
				text_q      <= 1'b0;
				key_q       <= '0;
				acc_q       <= '0;
				left_q      <= '0;
				main_q      <= '0;
				assist_q    <= '0;
				err_q       <= 1'b0;
				done_q      <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				skip_left_q <= skip_left_n;
				pos_q       <= pos_n;
				sub_q       <= sub_n;
				width_q     <= width_n;
				text_q      <= text_n;
				key_q       <= key_n;
				acc_q       <= acc_n;
				left_q      <= left_n;
				main_q      <= main_n;
				assist_q    <= assist_n;
				err_q       <= err_n;
				done_q      <= done_n;
			end
		end
	end

endmodule

// File: rtl/tlvp_queue.sv
module tlvp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  tlvp_pkg::rec_t  rec0,
	input  tlvp_pkg::rec_t  rec1,
	input  tlvp_pkg::push_t push,
	output logic            room,
	output logic            head_valid,
	output tlvp_pkg::rec_t  head,
	input  logic            pop_ready
);

	localparam int DEPTH = tlvp_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	tlvp_pkg::rec_t  entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            pop;

	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign pop        = head_valid && pop_ready;
	// take an item only with room for both of its records
	assign room       = count_q <= CNTW'(DEPTH - 2);

	// write up to two records per cycle
	always_ff @(posedge clk) begin
		if (push.first) begin
			entry_q[wr_ptr_q] <= rec0;
		end
		if (push.second) begin
			entry_q[wr_ptr_q + AW'(1)] <= rec1;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.first) + AW'(push.second);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			count_q  <= count_q + CNTW'(push.first) + CNTW'(push.second) - CNTW'(pop);
		end
	end

endmodule

// File: rtl/tlv_packet_parser_top.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: data_byte; s_tlast: last_byte
// m_        out  m_tvalid/m_tready  m_tdata: field record or status;
//                                   m_tuser: record_kind; m_tlast: end_of_run
// cfg_      in   cfg_wr_en          cfg_wr_data: skip_bytes
//
// One byte is accepted per cycle; its state update is done in the same cycle
// and its records go into a four-entry result queue, so a record can be seen
// on m_ the cycle after its byte. A last byte that closes a field makes two
// records; the queue drains one record per cycle while m_tready is high.
// s_tready drops while the queue has room for fewer than two records.
// arst_n clears the parse state, the skip register and the queue.
module tlv_packet_parser_top #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] field_key, [8] is_text, [40:9] value_offset, [72:41] value_length,
	// [136:73] number_value, [152:137] main_id, [168:153] assist_id,
	// [169] packet_valid, [175:170] zero
	output logic [tlvp_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic        m_tuser,   // [0] record_kind
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	tlvp_pkg::rec_t  rec0;
	tlvp_pkg::rec_t  rec1;
	tlvp_pkg::push_t push;
	tlvp_pkg::rec_t  head;
	logic            room;
	logic            accept;

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	tlvp_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.data_byte   (s_tdata),
		.last_byte   (s_tlast),
		.rec0        (rec0),
		.rec1        (rec1),
		.push        (push)
	);

	tlvp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec0       (rec0),
		.rec1       (rec1),
		.push       (push),
		.room       (room),
		.head_valid (m_tvalid),
		.head       (head),
		.pop_ready  (m_tready)
	);

	// pack the head record
	assign m_tdata = {6'b0, head.valid, head.assist_id, head.main_id, head.number,
		head.length, head.offset, head.is_text, head.key};
	assign m_tuser = head.kind;
	assign m_tlast = head.eor;

endmodule
